// File: rtl/gcsf_pkg.sv
// Shared types and constants for the greedy compatible split filter.
// No dependencies; imported by the top level.
package gcsf_pkg;

    // Fixed field widths
    localparam int SPLIT_W = 64;
    localparam int SUP_W   = 16;
    localparam int CNT_W   = 6;
    localparam int CFG_W   = 16;
    localparam int CFG_AW  = 2;
    localparam int STAT_W  = 3;

    // Stream payload widths (whole bytes)
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_MIN_SUPPORT = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_THR_SUPPORT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_SPLIT_CAP   = 2'd2;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_MAJORITY   = 3'd0,
        ST_COMPATIBLE = 3'd1,
        ST_BELOW_MIN  = 3'd2,
        ST_CONFLICT   = 3'd3,
        ST_FULL       = 3'd4
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DONE
    } fsm_state_t;

endpackage

// File: rtl/gcsf_store.sv
// Split store: single-port-write, single-port-read synchronous memory.
// Read data is registered. No package dependencies.
module gcsf_store #(
    parameter int DEPTH = 61,
    parameter int WIDTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/greedy_compatible_split_filter.sv
// Top level of the greedy compatible split filter.
// Depends on gcsf_pkg and the split store gcsf_store.

// One request is handled at a time. A candidate that is discarded, hits a
// full store, reaches the majority threshold, or meets an empty store goes
// from IDLE straight to DONE. A candidate that needs the compatibility
// check passes through SCAN first: the kept splits are read from the
// split store one entry per cycle through its single read port, and the
// scan stops early at the first conflict. A new request is taken
// while the previous result still waits on the output register. No
// clearing pass follows reset; kept entries are only read below the count.
module greedy_compatible_split_filter
    import gcsf_pkg::*;
#(
    parameter int TAXA        = 64,
    parameter int SPLIT_SLOTS = 61
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_AW-1:0]      cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata,
    // Candidate stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // split_bits[63:0], support[79:64]
    input  logic [0:0]             s_tuser,   // first_of_set[0]
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // status[2:0], slot[8:3],
                                              // kept_count[14:9], zero[15]
);

    localparam int IDX_W = (SPLIT_SLOTS > 1) ? $clog2(SPLIT_SLOTS) : 1;
    localparam logic [CNT_W-1:0] MAX_LIM = CNT_W'(SPLIT_SLOTS);

    // Configuration registers
    logic [SUP_W-1:0] min_support_reg;
    logic [SUP_W-1:0] thr_support_reg;
    logic [CNT_W-1:0] split_cap_reg;

    // Control and datapath registers
    fsm_state_t       state_reg,  state_next;
    logic [TAXA-1:0]  cand_reg,   cand_next;
    status_t          status_reg, status_next;
    logic [CNT_W-1:0] total_reg,  total_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             chk_vld_reg, chk_vld_next;

    // Output register
    logic             m_tvalid_reg, m_tvalid_next;
    status_t          out_status_reg, out_status_next;
    logic [CNT_W-1:0] out_slot_reg,   out_slot_next;
    logic [CNT_W-1:0] out_count_reg,  out_count_next;

    // Memory interface
    logic             wr_en;
    logic             rd_en;
    logic [TAXA-1:0]  rd_data;

    // Decode of the incoming request
    logic [TAXA-1:0]  in_cand;
    logic [SUP_W-1:0] in_sup;
    logic             in_first;
    logic [CNT_W-1:0] in_base;
    logic [CNT_W-1:0] limit;
    logic             compatible;
    logic             load_out;

    assign in_cand  = s_tdata[TAXA-1:0];
    assign in_sup   = s_tdata[SPLIT_W +: SUP_W];
    assign in_first = s_tuser[0];
    assign in_base  = in_first ? '0 : total_reg;
    assign limit    = (split_cap_reg > MAX_LIM) ? MAX_LIM : split_cap_reg;

    // Two splits are compatible when one of the three overlaps is empty
    assign compatible = ((cand_reg & rd_data) == '0)
                     || ((cand_reg & ~rd_data) == '0)
                     || ((~cand_reg & rd_data) == '0);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_support_reg <= '0;
            thr_support_reg <= SUP_W'(1);
            split_cap_reg   <= CNT_W'(61);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MIN_SUPPORT: min_support_reg <= cfg_wdata;
                CFG_THR_SUPPORT: thr_support_reg <= cfg_wdata;
                CFG_SPLIT_CAP:   split_cap_reg   <= cfg_wdata[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FSM_IDLE;
            total_reg    <= '0;
            chk_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            chk_vld_reg  <= chk_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cand_reg       <= cand_next;
        status_reg     <= status_next;
        scan_idx_reg   <= scan_idx_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_count_reg  <= out_count_next;
    end

    // Next state, scan control and result formation
    always_comb
    begin
        state_next      = state_reg;
        cand_next       = cand_reg;
        status_next     = status_reg;
        total_next      = total_reg;
        scan_idx_next   = scan_idx_reg;
        chk_vld_next    = 1'b0;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_count_next  = out_count_reg;
        s_tready        = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        load_out        = 1'b0;

        unique case (state_reg)
            FSM_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    // Take the request, clear the set if asked, classify
                    cand_next     = in_cand;
                    total_next    = in_base;
                    scan_idx_next = '0;
                    state_next    = FSM_DONE;
                    priority if (in_sup < min_support_reg)
                        status_next = ST_BELOW_MIN;
                    else if (in_base >= limit)
                        status_next = ST_FULL;
                    else if (in_sup >= thr_support_reg)
                        status_next = ST_MAJORITY;
                    else
                    begin
                        status_next = ST_COMPATIBLE;
                        if (in_base != '0)
                        begin
                            state_next = FSM_SCAN;
                        end
                    end
                end
            end

            FSM_SCAN:
            begin
                // Issue one read per cycle while entries remain
                rd_en = (scan_idx_reg < total_reg);
                if (rd_en)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                chk_vld_next = rd_en;
                // Check the entry read in the previous cycle
                if (chk_vld_reg)
                begin
                    if (!compatible)
                    begin
                        status_next  = ST_CONFLICT;
                        chk_vld_next = 1'b0;
                        state_next   = FSM_DONE;
                    end
                    else if (!rd_en)
                    begin
                        state_next = FSM_DONE;
                    end
                end
            end

            FSM_DONE:
            begin
                // Commit and hand the result to the output register
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out        = 1'b1;
                    wr_en           = (status_reg == ST_MAJORITY)
                                   || (status_reg == ST_COMPATIBLE);
                    total_next      = wr_en ? total_reg + CNT_W'(1) : total_reg;
                    m_tvalid_next   = 1'b1;
                    out_status_next = status_reg;
                    out_slot_next   = wr_en ? total_reg : '0;
                    out_count_next  = total_next;
                    state_next      = FSM_IDLE;
                end
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Kept split store
    gcsf_store #(
        .DEPTH (SPLIT_SLOTS),
        .WIDTH (TAXA),
        .AW    (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (total_reg[IDX_W-1:0]),
        .wr_data (cand_reg),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Result stream outputs
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_slot_reg, out_status_reg};

`ifndef SYNTHESIS
    // Count of kept splits never passes the store depth
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= MAX_LIM)
        else $error("kept count exceeds store depth");

    // An accepted split reports the slot just below the new count
    a_slot_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && ((out_status_reg == ST_MAJORITY)
                       || (out_status_reg == ST_COMPATIBLE)))
        |-> (out_slot_reg + CNT_W'(1) == out_count_reg))
        else $error("slot and kept count disagree");

    // A rejected request leaves the count unchanged
    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !wr_en) |=> (total_reg == $past(total_reg)))
        else $error("rejected request changed the kept count");

    // A conflict needs at least one kept split
    a_conflict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (out_status_reg == ST_CONFLICT))
        |-> (out_count_reg != '0))
        else $error("conflict reported against an empty store");
`endif

endmodule

// File: tb/sv/split_verdict_pkg.sv
// Scoreboard for the split filter bench: predicts the verdict on each
// accepted candidate and checks returned results in order.
// Depends on gcsf_pkg for field widths, register indexes and status codes.
package split_verdict_pkg;
    import gcsf_pkg::*;

    localparam int KEPT_DEPTH = 61;
    // All 64 taxa are in use, so no bit of a split is dropped
    localparam logic [SPLIT_W-1:0] TAXA_MASK = '1;

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] slot;
        logic [CNT_W-1:0] kept_count;
    } verdict_t;

    class split_verdict_board;
        logic [SPLIT_W-1:0] kept_vec [KEPT_DEPTH];
        int                 kept_cnt;
        logic [SUP_W-1:0]   min_sup;
        logic [SUP_W-1:0]   thr_sup;
        logic [CNT_W-1:0]   split_limit;
        verdict_t           pending_verdicts [$];
        int                 mismatches;
        int                 checked;
        int                 status_seen [5];

        function new();
            kept_cnt    = 0;
            min_sup     = '0;
            thr_sup     = SUP_W'(1);
            split_limit = CNT_W'(61);
            mismatches  = 0;
            checked     = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        // Mirror a register write
        function void set_register(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_MIN_SUPPORT: min_sup = data;
                CFG_THR_SUPPORT: thr_sup = data;
                CFG_SPLIT_CAP:   split_limit = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Two splits agree when a misses b, a misses ~b, or ~a misses b
        function bit splits_agree(logic [SPLIT_W-1:0] a, logic [SPLIT_W-1:0] b);
            return ((a & b) == '0) || ((a & ~b & TAXA_MASK) == '0) ||
                   ((~a & TAXA_MASK & b) == '0);
        endfunction

        // Decide the verdict on an accepted candidate and queue it
        function void note_candidate(logic [SPLIT_W-1:0] bits, logic [SUP_W-1:0] sup,
                                     logic first);
            verdict_t           v;
            logic [SPLIT_W-1:0] cand;
            int                 lim;
            cand = bits & TAXA_MASK;
            if (first)
                kept_cnt = 0;
            lim = (split_limit > KEPT_DEPTH) ? KEPT_DEPTH : int'(split_limit);
            v.slot = '0;
            if (sup < min_sup)
                v.status = ST_BELOW_MIN;
            else if (kept_cnt >= lim)
                v.status = ST_FULL;
            else
            begin
                if (sup >= thr_sup)
                    v.status = ST_MAJORITY;
                else
                begin
                    v.status = ST_COMPATIBLE;
                    for (int j = 0; j < kept_cnt; j++)
                    begin
                        if (!splits_agree(cand, kept_vec[j]))
                        begin
                            v.status = ST_CONFLICT;
                            break;
                        end
                    end
                end
                // store the split in the next free slot
                if (v.status != ST_CONFLICT)
                begin
                    v.slot = CNT_W'(kept_cnt);
                    kept_vec[kept_cnt] = cand;
                    kept_cnt++;
                end
            end
            v.kept_count = CNT_W'(kept_cnt);
            pending_verdicts.push_back(v);
        endfunction

        function int waiting();
            return pending_verdicts.size();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        // Compare a returned result with the oldest verdict
        task check_verdict(logic [OUT_TDATA_W-1:0] word);
            verdict_t          want;
            logic [STAT_W-1:0] got_status;
            logic [CNT_W-1:0]  got_slot;
            logic [CNT_W-1:0]  got_count;
            got_status = word[STAT_W-1:0];
            got_slot   = word[STAT_W+CNT_W-1:STAT_W];
            got_count  = word[STAT_W+2*CNT_W-1:STAT_W+CNT_W];
            checked++;
            if (pending_verdicts.size() == 0)
            begin
                report($sformatf("result %0d (0x%04h) with no request pending",
                                 checked, word));
                return;
            end
            want = pending_verdicts.pop_front();
            status_seen[int'(want.status)]++;
            if (got_status !== want.status)
                report($sformatf("result %0d status %0d, expected %0d",
                                 checked, got_status, want.status));
            if (got_slot !== want.slot)
                report($sformatf("result %0d slot %0d, expected %0d",
                                 checked, got_slot, want.slot));
            if (got_count !== want.kept_count)
                report($sformatf("result %0d kept_count %0d, expected %0d",
                                 checked, got_count, want.kept_count));
        endtask
    endclass

endpackage

// File: tb/sv/testbench.sv
// Bench for greedy_compatible_split_filter: directed and random split sets
// under many register settings, with random idling on both streams.
// Depends on gcsf_pkg, split_verdict_pkg and the filter RTL.
module testbench;
    import gcsf_pkg::*;
    import split_verdict_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_AW-1:0]      cfg_addr  = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    split_verdict_board board = new();

    bit calm      = 1'b0;
    bit hold_ask  = 1'b0;
    int candidates = 0;
    int settings   = 0;
    int holds_done = 0;

    greedy_compatible_split_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, a few long ones; none in a calm phase
    function automatic int pause_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [SUP_W-1:0] sat_support(int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return SUP_W'(v);
    endfunction

    // Pick a candidate split: aligned blocks never clash with each other,
    // plain intervals and their complements often do
    function automatic logic [SPLIT_W-1:0] shaped_split();
        logic [SPLIT_W-1:0] ones;
        int                 pick;
        int                 width;
        int                 lo;
        int                 hi;
        ones = '1;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            width = 1 << $urandom_range(0, 6);
            lo = width * $urandom_range(0, 64 / width - 1);
            return (ones >> (64 - width)) << lo;
        end
        if (pick < 85)
        begin
            lo = $urandom_range(0, 63);
            hi = $urandom_range(lo, 63);
            if (pick < 75)
                return (ones >> (63 - (hi - lo))) << lo;
            return ~((ones >> (63 - (hi - lo))) << lo);
        end
        return {$urandom, $urandom};
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic offer(logic [SPLIT_W-1:0] bits, logic [SUP_W-1:0] sup, logic first);
        int gap;
        gap = pause_cycles();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sup, bits};
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_candidate(bits, sup, first);
        candidates++;
    endtask

    // One set sorted by falling support, starting near the threshold
    task automatic offer_set(int thr, int longest);
        int len;
        int sup;
        len = $urandom_range(1, longest);
        sup = thr + 15 - $urandom_range(0, 10);
        for (int k = 0; k < len; k++)
        begin
            offer(shaped_split(), sat_support(sup), k == 0);
            sup -= $urandom_range(0, 3);
        end
    endtask

    // Unstructured requests: every field fully random
    task automatic offer_noise();
        int n;
        n = $urandom_range(1, 5);
        repeat (n)
            offer({$urandom, $urandom}, SUP_W'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)));
    endtask

    // Drop the request line and wait until every result is back
    task automatic wait_drained(int settle);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.waiting() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.set_register(idx, data);
    endtask

    task automatic write_settings(int mins, int thr, logic [CFG_W-1:0] max_word);
        write_register(CFG_MIN_SUPPORT, sat_support(mins));
        write_register(CFG_THR_SUPPORT, sat_support(thr));
        write_register(CFG_SPLIT_CAP, max_word);
        settings++;
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_ask && hold_left == 0)
            begin
                hold_left = 300;
                hold_ask  = 1'b0;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pause_cycles();
            end
        end
    end

    // Check every result taken
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_verdict(m_tdata);
    end

    initial
    begin
        #12_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int               thr;
        int               mins;
        int               maxs;
        int               budget;
        logic [CFG_W-1:0] max_word;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: zero support goes through the compatibility check
        offer('1, 16'd0, 1'b1);
        offer('0, 16'd0, 1'b0);
        offer(64'h0F, 16'd0, 1'b0);
        offer(64'hF0, 16'd0, 1'b0);
        offer(64'h3C, 16'd0, 1'b0);
        offer(64'h3C, 16'hFFFF, 1'b0);
        offer({$urandom, $urandom}, 16'd1, 1'b0);
        offer(64'h8000_0000_0000_0000, 16'd0, 1'b1);
        wait_drained(4);

        // Minimum above threshold; limit written as 63 saturates to 61
        write_settings(65535, 0, 16'hFFFF);
        offer('1, 16'hFFFE, 1'b1);
        offer('1, 16'hFFFF, 1'b0);
        offer('0, 16'd0, 1'b0);
        wait_drained(4);

        // Zero limit, with junk above the register width
        write_settings(0, 65535, 16'h0040);
        offer(64'h1, 16'd0, 1'b1);
        offer('1, 16'hFFFF, 1'b0);
        wait_drained(4);

        // Limit of one split
        write_settings(100, 200, 16'd1);
        offer(64'h5, 16'd300, 1'b1);
        offer(64'h5, 16'd150, 1'b0);
        offer(64'h5, 16'd50, 1'b0);
        offer(64'hA, 16'd150, 1'b1);
        offer(64'h6, 16'd199, 1'b0);
        wait_drained(4);

        // Random phases, each under its own settings
        for (int phase = 0; phase < 12; phase++)
        begin
            calm = (phase == 0 || phase == 5);
            case (phase)
                0:
                begin
                    mins = 0;
                    thr  = 65535;
                    maxs = 61;
                end
                1:
                begin
                    mins = 0;
                    thr  = 0;
                    maxs = 63;
                end
                2:
                begin
                    mins = 65535;
                    thr  = 65535;
                    maxs = 62;
                end
                default:
                begin
                    thr = $urandom_range(0, 65535);
                    if ($urandom_range(0, 4) == 0)
                        mins = thr + $urandom_range(1, 20);
                    else
                        mins = thr - $urandom_range(0, 60);
                    if ($urandom_range(0, 1) == 1)
                        maxs = $urandom_range(59, 63);
                    else
                        maxs = $urandom_range(0, 20);
                end
            endcase
            max_word = CFG_W'(($urandom_range(0, 1023) << CNT_W) | maxs);
            write_settings(mins, thr, max_word);
            if (phase == 3)
                hold_ask = 1'b1;
            budget = candidates + 125;
            while (candidates < budget)
            begin
                if ($urandom_range(0, 99) < 85)
                    offer_set(thr, (maxs >= 59) ? 75 : 30);
                else
                    offer_noise();
            end
            wait_drained(4);
        end

        wait_drained(70);
        $display("Covered %0d candidates under %0d register settings, %0d long hold-off(s).",
                 candidates, settings, holds_done);
        $display("Verdicts: majority %0d, compatible %0d, below minimum %0d,",
                 board.status_seen[ST_MAJORITY], board.status_seen[ST_COMPATIBLE],
                 board.status_seen[ST_BELOW_MIN]);
        $display("          conflict %0d, full %0d.",
                 board.status_seen[ST_CONFLICT], board.status_seen[ST_FULL]);
        if (board.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
